[design/mrrb_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-region ring buffer package
// Operation codes and default sizes shared by the ring buffer and its checker.
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam int RING_SIZE_DEF     = 256;
    localparam int REGION_COUNT_DEF  = 3;
    localparam int ELEMENT_WIDTH_DEF = 8;
    localparam int OP_WIDTH          = 3;

    localparam logic [OP_WIDTH-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_READ  = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_MOVE  = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_CLAIM = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_TAKE  = 3'd4;

endpackage

[design/multi_region_ring_buffer.sv]
// An accepted input beat passes through the input register, then its result beat is held in the output register.
// Throughput: one beat per cycle while the result output is not stalled; a fired beat updates region start and count.
// The element memory is read on the same edge that updates the region registers.
// Reset clears the region registers (region 0 owns the whole ring) and all valids.
// Ring contents are not cleared; no clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
// Multi-region ring buffer
// Ring store split into consecutive regions, each with a start index and a
// count; operations consume elements at a region head and hand them onward.
// ----------------------------------------------------------------------------
module multi_region_ring_buffer #(
    parameter int RING_SIZE     = mrrb_pkg::RING_SIZE_DEF,
    parameter int REGION_COUNT  = mrrb_pkg::REGION_COUNT_DEF,
    parameter int ELEMENT_WIDTH = mrrb_pkg::ELEMENT_WIDTH_DEF,
    localparam int IW = $clog2(RING_SIZE),
    localparam int CW = $clog2(RING_SIZE + 1),
    localparam int RW = $clog2(REGION_COUNT)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mrrb_pkg::OP_WIDTH-1:0] i_operation,
    input  logic [RW-1:0]                 i_from_region,
    input  logic [RW-1:0]                 i_to_region,
    input  logic [CW-1:0]                 i_amount,
    input  logic [ELEMENT_WIDTH-1:0]      i_write_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic [ELEMENT_WIDTH-1:0]      o_read_data,
    output logic [IW-1:0]                 o_segment_start,
    output logic [CW-1:0]                 o_segment_length
);

    localparam logic [RW:0] REGIONS = (RW + 1)'(REGION_COUNT);
    localparam logic [CW:0] RING    = (CW + 1)'(RING_SIZE);

    logic                          r_in_valid;
    logic [mrrb_pkg::OP_WIDTH-1:0] r_in_op;
    logic [RW-1:0]                 r_in_from;
    logic [RW-1:0]                 r_in_to;
    logic [CW-1:0]                 r_in_amount;
    logic [ELEMENT_WIDTH-1:0]      r_in_wdata;

    logic [IW-1:0]            r_start [REGION_COUNT];
    logic [CW-1:0]            r_count [REGION_COUNT];
    logic [IW-1:0]            n_start [REGION_COUNT];
    logic [CW-1:0]            n_count [REGION_COUNT];
    logic [ELEMENT_WIDTH-1:0] r_mem   [RING_SIZE];

    logic                     r_out_valid;
    logic                     r_out_ok;
    logic                     r_out_is_read;
    logic [ELEMENT_WIDTH-1:0] r_rd_data;
    logic [IW-1:0]            r_out_start;
    logic [CW-1:0]            r_out_len;

    logic          advance;
    logic          fire;
    logic          idx_ok;
    logic          op_ok;
    logic          ok_all;
    logic          upd;
    logic [RW-1:0] sel_f;
    logic [RW-1:0] sel_t;
    logic [IW-1:0] cur_start;
    logic [CW-1:0] cur_count;
    logic [CW:0]   span_end;
    logic [CW-1:0] run;
    logic [CW-1:0] num;
    logic [CW:0]   start_sum;
    logic [CW:0]   start_wrap;
    logic [IW-1:0] new_start;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign fire    = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_op     <= i_operation;
            r_in_from   <= i_from_region;
            r_in_to     <= i_to_region;
            r_in_amount <= i_amount;
            r_in_wdata  <= i_write_data;
        end
    end

    always_comb begin
        idx_ok    = ({1'b0, r_in_from} < REGIONS) && ({1'b0, r_in_to} < REGIONS);
        sel_f     = idx_ok ? r_in_from : '0;
        sel_t     = idx_ok ? r_in_to : '0;
        cur_start = r_start[sel_f];
        cur_count = r_count[sel_f];
        span_end  = (CW + 1)'(cur_start) + (CW + 1)'(cur_count);
        run       = (span_end <= RING) ? cur_count : CW'(RING_SIZE) - CW'(cur_start);
        op_ok     = 1'b0;
        num       = '0;
        case (r_in_op)
            mrrb_pkg::OP_WRITE, mrrb_pkg::OP_READ: begin
                op_ok = (cur_count != '0);
                num   = CW'(1);
            end
            mrrb_pkg::OP_MOVE: begin
                op_ok = (r_in_amount <= cur_count);
                num   = r_in_amount;
            end
            mrrb_pkg::OP_CLAIM: begin
                op_ok = (r_in_amount <= run);
                num   = r_in_amount;
            end
            mrrb_pkg::OP_TAKE: begin
                op_ok = 1'b1;
                num   = run;
            end
            default: begin
                op_ok = 1'b0;
                num   = '0;
            end
        endcase
        ok_all     = idx_ok && op_ok;
        upd        = fire && ok_all;
        start_sum  = (CW + 1)'(cur_start) + (CW + 1)'(num);
        start_wrap = (start_sum >= RING) ? start_sum - RING : start_sum;
        new_start  = IW'(start_wrap);
    end

    always_comb begin
        for (int i = 0; i < REGION_COUNT; i++) begin
            n_start[i] = r_start[i];
            n_count[i] = r_count[i];
            if (upd && RW'(i) == sel_f) begin
                n_start[i] = new_start;
                n_count[i] = n_count[i] - num;
            end
            if (upd && RW'(i) == sel_t) begin
                n_count[i] = n_count[i] + num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGION_COUNT; i++) begin
                r_start[i] <= '0;
                r_count[i] <= (i == 0) ? CW'(RING_SIZE) : '0;
            end
        end else begin
            for (int i = 0; i < REGION_COUNT; i++) begin
                r_start[i] <= n_start[i];
                r_count[i] <= n_count[i];
            end
        end
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (upd && r_in_op == mrrb_pkg::OP_WRITE) begin
            r_mem[cur_start] <= r_in_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd_data <= r_mem[cur_start];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_ok      <= ok_all;
            r_out_is_read <= ok_all && (r_in_op == mrrb_pkg::OP_READ);
            r_out_start   <= ok_all ? cur_start : '0;
            r_out_len     <= ok_all ? num : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accepted       = r_out_ok;
    assign o_read_data      = r_out_is_read ? r_rd_data : '0;
    assign o_segment_start  = r_out_start;
    assign o_segment_length = r_out_len;

endmodule

[design/mrrb_checker.sv]
// ----------------------------------------------------------------------------
// Multi-region ring buffer checker
// Port-level checks on the result channel and the input stall.
// ----------------------------------------------------------------------------
module mrrb_checker #(
    parameter int RING_SIZE     = mrrb_pkg::RING_SIZE_DEF,
    parameter int REGION_COUNT  = mrrb_pkg::REGION_COUNT_DEF,
    parameter int ELEMENT_WIDTH = mrrb_pkg::ELEMENT_WIDTH_DEF,
    localparam int IW = $clog2(RING_SIZE),
    localparam int CW = $clog2(RING_SIZE + 1),
    localparam int RW = $clog2(REGION_COUNT)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [mrrb_pkg::OP_WIDTH-1:0] i_operation,
    input logic [RW-1:0]                 i_from_region,
    input logic [RW-1:0]                 i_to_region,
    input logic [CW-1:0]                 i_amount,
    input logic [ELEMENT_WIDTH-1:0]      i_write_data,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_accepted,
    input logic [ELEMENT_WIDTH-1:0]      o_read_data,
    input logic [IW-1:0]                 o_segment_start,
    input logic [CW-1:0]                 o_segment_length
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_accepted) && $stable(o_read_data)
            && $stable(o_segment_start) && $stable(o_segment_length))
        else $error("stalled result beat changed");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_read_data == '0 && o_segment_start == '0
            && o_segment_length == '0)
        else $error("refused beat carries nonzero fields");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_segment_length <= CW'(RING_SIZE))
        else $error("segment length beyond ring size");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result beat");

endmodule

bind multi_region_ring_buffer mrrb_checker #(
    .RING_SIZE     (RING_SIZE),
    .REGION_COUNT  (REGION_COUNT),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_mrrb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_operation      (i_operation),
    .i_from_region    (i_from_region),
    .i_to_region      (i_to_region),
    .i_amount         (i_amount),
    .i_write_data     (i_write_data),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_accepted       (o_accepted),
    .o_read_data      (o_read_data),
    .o_segment_start  (o_segment_start),
    .o_segment_length (o_segment_length)
);
